// ===== rtl/core/nsab_pkg.sv =====
// Shared types, operation codes and nibble helpers for the nibble strobe/ack bus master.
// Used by nsab_step and nibble_strobe_ack_bus_master_top; no other dependencies.
package nsab_pkg;

    localparam int STABLE_SAMPLES_DEF = 3;
    localparam int RUN_W              = 4;   // holds up to 15 equal samples
    localparam int S_TDATA_W          = 40;
    localparam int S_TUSER_W          = 4;
    localparam int M_TDATA_W          = 24;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_CMD   = 4'd1,
        OP_ADDR  = 4'd2,
        OP_WBYTE = 4'd3,
        OP_WNIB  = 4'd4,
        OP_RBYTE = 4'd5,
        OP_RNIB  = 4'd6,
        OP_WFIN  = 4'd7,
        OP_RFIN  = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  cmd_code;
        logic [15:0] address;
        logic [7:0]  wr_data;
        logic        ack_in;
        logic        req_echo_in;
        logic [3:0]  rd_nibble_in;
    } t_item;

    typedef struct packed {
        logic        req_out;
        logic        stb_out;
        logic [3:0]  nibble_out;
        logic        bus_input_mode;
        logic        busy_res;
        logic        op_done;
        logic [7:0]  rd_data;
        logic        rd_valid;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [2:0]       phase;
        logic             wait_lvl;
        logic [5:0]       prev;
        logic [RUN_W-1:0] run;
        logic [7:0]       read_hold;
        logic             req;
        logic             stb;
        logic [3:0]       nib;
        logic             inmode;
        logic [15:0]      operand;
    } t_state;

    function automatic logic [2:0] nibble_count(input t_op k);
        case (k)
            OP_CMD:   nibble_count = 3'd1;
            OP_ADDR:  nibble_count = 3'd4;
            OP_WBYTE: nibble_count = 3'd2;
            OP_WNIB:  nibble_count = 3'd1;
            OP_RBYTE: nibble_count = 3'd2;
            OP_RNIB:  nibble_count = 3'd1;
            default:  nibble_count = 3'd0;
        endcase
    endfunction

    function automatic logic [3:0] nibble_value(input t_op k, input logic [15:0] opnd,
                                                input logic [2:0] ph);
        case (k)
            OP_CMD:  nibble_value = opnd[3:0];
            OP_WNIB: nibble_value = opnd[3:0];
            OP_ADDR: begin
                case (ph[1:0])
                    2'd0:    nibble_value = opnd[15:12];
                    2'd1:    nibble_value = opnd[11:8];
                    2'd2:    nibble_value = opnd[7:4];
                    default: nibble_value = opnd[3:0];
                endcase
            end
            OP_WBYTE: nibble_value = (ph == 3'd0) ? opnd[7:4] : opnd[3:0];
            default:  nibble_value = 4'd0;
        endcase
    endfunction

    // Command nibbles 1 and 4 and the second nibble of byte transfers release request.
    function automatic logic drops_request(input t_op k, input logic [15:0] opnd,
                                           input logic [2:0] ph);
        case (k)
            OP_CMD:   drops_request = (opnd[3:0] == 4'd1) || (opnd[3:0] == 4'd4);
            OP_WBYTE: drops_request = (ph == 3'd1);
            OP_RBYTE: drops_request = (ph == 3'd1);
            default:  drops_request = 1'b0;
        endcase
    endfunction

endpackage

// ===== rtl/core/nibble_strobe_ack_bus_master_top.sv =====
// Each item passes through an input register, then a result register, before the result transfer.
// Throughput: one item per cycle while the result side is not stalled; the handshake state advances once per item.
// Ack levels on filtered operations count STABLE_SAMPLES equal consecutive tick items.
// Reset (synchronous, active low) idles the controller, drives all lines low in output
// mode and empties both pipeline registers.
// Depends on nsab_pkg and nsab_step.
module nibble_strobe_ack_bus_master_top
    import nsab_pkg::*;
#(
    parameter int STABLE_SAMPLES = STABLE_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [3:0] cmd_code, [19:4] address, [27:20] wr_data, [28] ack_in, [29] req_echo_in,
    // [33:30] rd_nibble_in, [39:34] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [3:0] command
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] req_out, [1] stb_out, [5:2] nibble_out, [6] bus_input_mode, [7] busy_res,
    // [8] op_done, [16:9] rd_data, [17] rd_valid, [23:18] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_item   in_item;
    logic    advance;
    logic    in_xfer;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        in_item.command      = i_s_axis_tuser[3:0];
        in_item.cmd_code     = i_s_axis_tdata[3:0];
        in_item.address      = i_s_axis_tdata[19:4];
        in_item.wr_data      = i_s_axis_tdata[27:20];
        in_item.ack_in       = i_s_axis_tdata[28];
        in_item.req_echo_in  = i_s_axis_tdata[29];
        in_item.rd_nibble_in = i_s_axis_tdata[33:30];
    end

    nsab_step #(
        .STABLE_SAMPLES (STABLE_SAMPLES)
    ) u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{op: OP_IDLE, default: '0};
        end else begin
            if (in_xfer)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer)
            r_in <= in_item;
        if (advance)
            r_out <= n_result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.rd_valid, r_out.rd_data, r_out.op_done,
                              r_out.busy_res, r_out.bus_input_mode, r_out.nibble_out,
                              r_out.stb_out, r_out.req_out};

    // strobe is always up while a nibble waits for ack high
    a_wait_stb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.wait_lvl |-> r_state.stb)
        else $error("waiting for ack high with strobe low");

    a_idle_stb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.op == OP_IDLE) |-> (!r_state.stb && !r_state.wait_lvl))
        else $error("strobe left high with no operation");

    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rd_valid) |-> (r_out.op_done && !r_out.busy_res))
        else $error("read data without completion");

endmodule

// ===== rtl/core/nsab_step.sv =====
// Next-state and result logic for one item of the bus master handshake.
// Depends on nsab_pkg (state, item and result types, nibble helpers).
module nsab_step
    import nsab_pkg::*;
#(
    parameter int STABLE_SAMPLES = STABLE_SAMPLES_DEF
) (
    input  t_item   i_item,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    localparam logic [RUN_W-1:0] RunLimit = RUN_W'(STABLE_SAMPLES);

    always_comb begin
        t_state           s;
        logic             done;
        logic             rd_done;
        logic             ok;
        logic             filt;
        logic [5:0]       smp;
        logic [RUN_W-1:0] run_n;
        logic [2:0]       ph_n;
        t_op              cmd;

        s       = i_state;
        done    = 1'b0;
        rd_done = 1'b0;
        ok      = 1'b0;
        smp     = {i_item.ack_in, i_item.req_echo_in, i_item.rd_nibble_in};
        run_n   = '0;
        ph_n    = i_state.phase + 3'd1;
        cmd     = t_op'(i_item.command);
        filt    = (i_state.op == OP_WNIB) || (i_state.op == OP_RBYTE) ||
                  (i_state.op == OP_RNIB);

        if (i_state.op != OP_IDLE) begin
            if (i_state.op == OP_WFIN || i_state.op == OP_RFIN) begin
                if (!i_item.req_echo_in) begin
                    if (i_state.op == OP_RFIN)
                        s.inmode = 1'b0;
                    s.op = OP_IDLE;
                    done = 1'b1;
                end
            end else begin
                if (filt) begin
                    // count equal consecutive samples, saturating at the limit
                    if (i_state.run != '0 && smp == i_state.prev)
                        run_n = (i_state.run < RunLimit) ? i_state.run + 1'b1 : i_state.run;
                    else
                        run_n = RUN_W'(1);
                    s.run  = run_n;
                    s.prev = smp;
                    ok = (run_n >= RunLimit) && (i_item.ack_in == i_state.wait_lvl);
                end else begin
                    ok = (i_item.ack_in == i_state.wait_lvl);
                end

                if (ok) begin
                    if (i_state.wait_lvl) begin
                        if (i_state.op == OP_RBYTE || i_state.op == OP_RNIB)
                            s.read_hold = {i_state.read_hold[3:0], i_item.rd_nibble_in};
                        s.req = !drops_request(i_state.op, i_state.operand, i_state.phase);
                        s.stb      = 1'b0;
                        s.nib      = 4'd0;
                        s.wait_lvl = 1'b0;
                        s.run      = '0;
                    end else begin
                        s.phase = ph_n;
                        if (ph_n < nibble_count(i_state.op)) begin
                            s.req      = 1'b1;
                            s.stb      = 1'b1;
                            s.nib      = nibble_value(i_state.op, i_state.operand, ph_n);
                            s.wait_lvl = 1'b1;
                            s.run      = '0;
                        end else begin
                            if (i_state.op == OP_RBYTE)
                                s.inmode = 1'b0;
                            s.op    = OP_IDLE;
                            done    = 1'b1;
                            rd_done = (i_state.op == OP_RBYTE) || (i_state.op == OP_RNIB);
                        end
                    end
                end
            end
        end else if (cmd inside {[OP_CMD:OP_RFIN]}) begin
            s.op        = cmd;
            s.phase     = 3'd0;
            s.run       = '0;
            s.read_hold = 8'd0;
            case (cmd)
                OP_CMD:   s.operand = {12'd0, i_item.cmd_code};
                OP_ADDR:  s.operand = i_item.address;
                OP_WBYTE: s.operand = {8'd0, i_item.wr_data};
                OP_WNIB:  s.operand = {8'd0, i_item.wr_data};
                default:  s.operand = i_state.operand;
            endcase
            if (cmd == OP_WFIN || cmd == OP_RFIN) begin
                s.req = 1'b0;
                s.stb = 1'b0;
                s.nib = 4'd0;
            end else begin
                if (cmd == OP_RBYTE)
                    s.inmode = 1'b1;
                s.req      = 1'b1;
                s.stb      = 1'b1;
                s.nib      = nibble_value(cmd, s.operand, 3'd0);
                s.wait_lvl = 1'b1;
            end
        end

        o_state                 = s;
        o_result.req_out        = s.req;
        o_result.stb_out        = s.stb;
        o_result.nibble_out     = s.nib;
        o_result.bus_input_mode = s.inmode;
        o_result.busy_res       = (s.op != OP_IDLE);
        o_result.op_done        = done;
        o_result.rd_data        = rd_done ? s.read_hold : 8'd0;
        o_result.rd_valid       = rd_done;
    end

endmodule
